/* src/aes128_ecb_encrypt_assert.svh */
// Assertion macros for the AES-128 ECB encrypt block checkers.
`ifndef AES128_ECB_ENCRYPT_ASSERT_SVH
`define AES128_ECB_ENCRYPT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define AES_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define AES_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds through reset.
`define AES_ASSERT_RAW(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* src/aes_pkg.sv */
// Shared types, constants and round functions for the AES-128 ECB encrypt block.
package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int NUM_STAGES = NUM_ROUNDS + 1;
   localparam logic [3:0] FIRST_ROUND = 4'd0;
   localparam logic [3:0] FINAL_ROUND = 4'd10;
   localparam logic [7:0] GF_POLY = 8'h1b;

   localparam logic [7:0] RCON [10] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // Request and result payloads; first member sits in the top bits.
   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        decrypt_request;
   } aes_req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        bad_mode;
   } aes_rsp_type;

   // What travels between pipeline stages.
   typedef struct packed {
      logic [127:0] state;
      logic [127:0] round_key;
      logic         bad_mode;
   } aes_stage_type;

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX[b];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   // Round constant for rounds 1..10, zero elsewhere.
   function automatic logic [7:0] round_const(input logic [3:0] rnd);
      if (rnd >= 4'd1 && rnd <= FINAL_ROUND) begin
         return RCON[rnd - 4'd1];
      end
      return 8'h00;
   endfunction

   // SubBytes and ShiftRows; byte i of the block is bits 127-8i down.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (c * 4 + r) -: 8] = sbox(s[127 - 8 * ((((c + r) & 3) * 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_state(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127 - 32 * c -: 8];
         a1  = s[119 - 32 * c -: 8];
         a2  = s[111 - 32 * c -: 8];
         a3  = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // One step of the key schedule: previous round key to the next one.
   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                  input logic [7:0]   rcon);
      logic [31:0] tw, n0, n1, n2, n3;
      tw = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
      n0 = rk[127:96] ^ tw;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = rk[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

/* src/aes_csr.sv */
// Key registers behind the APB-style configuration port.
module aes_csr (
   input  logic         clock,
   input  logic         reset,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready,
   output logic [127:0] key
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   logic        wr_en;

   // Write transfer on the access phase; bit 3 picks the 64-bit register.
   assign wr_en = psel & penable & pwrite & pready;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (wr_en) begin
         if (paddr[3]) begin
            key_low_in = pwdata;
         end else begin
            key_high_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[3] ? key_low_ff : key_high_ff;
   assign key    = {key_high_ff, key_low_ff};

endmodule

/* src/aes_round_stage.sv */
// One pipeline stage: initial key add, a full round, or the final round.
module aes_round_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             round_idx,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  aes_pkg::aes_stage_type in_stage,
   output logic                   out_valid,
   input  logic                   out_ready,
   output aes_pkg::aes_stage_type out_stage
);
   import aes_pkg::*;

   logic          valid_ff, valid_in;
   aes_stage_type stage_ff, stage_in;
   logic [127:0]  rk_next;
   logic [127:0]  sub_out;
   logic          load;

   // Stage takes a new transfer when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Round datapath with its own key schedule step.
   always_comb begin
      rk_next  = next_round_key(in_stage.round_key, round_const(round_idx));
      sub_out  = sub_shift(in_stage.state);
      stage_in = in_stage;
      if (round_idx == FIRST_ROUND) begin
         stage_in.state = in_stage.state ^ in_stage.round_key;
      end else if (round_idx == FINAL_ROUND) begin
         stage_in.round_key = rk_next;
         // Decrypt requests leave with a zero block.
         stage_in.state     = in_stage.bad_mode ? '0 : (sub_out ^ rk_next);
      end else begin
         stage_in.round_key = rk_next;
         stage_in.state     = mix_state(sub_out) ^ rk_next;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds while stalled.
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

/* src/aes128_ecb_encrypt.sv */
// A request passes through every stage register in turn; its result leaves from the last one
// and transfers once rsp_ready is high.
// Throughput: one block per cycle unless stalled, through eleven register stages
// (key add, ten rounds), each computing its own round key next to the round datapath.
// Stalls at the result port back up stage by stage; nothing is lost or repeated.
// Reset (synchronous): key registers go to zero and all stage valid bits clear.
module aes128_ecb_encrypt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aes_pkg::aes_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output aes_pkg::aes_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready
);
   import aes_pkg::*;

   logic [127:0]  key;
   logic          stg_valid [NUM_STAGES + 1];
   logic          stg_ready [NUM_STAGES + 1];
   aes_stage_type stg_data  [NUM_STAGES + 1];

   aes_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // Pipeline entry: block and the key in force at the transfer.
   assign stg_valid[0]          = req_valid;
   assign req_ready             = stg_ready[0];
   assign stg_data[0].state     = {req_data.block_high, req_data.block_low};
   assign stg_data[0].round_key = key;
   assign stg_data[0].bad_mode  = req_data.decrypt_request;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      aes_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .round_idx (4'(i)),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_stage  (stg_data[i]),
         .out_valid (stg_valid[i + 1]),
         .out_ready (stg_ready[i + 1]),
         .out_stage (stg_data[i + 1])
      );
   end

   // Last stage register is the output register.
   assign stg_ready[NUM_STAGES] = rsp_ready;
   assign rsp_valid             = stg_valid[NUM_STAGES];
   assign rsp_data.cipher_high  = stg_data[NUM_STAGES].state[127:64];
   assign rsp_data.cipher_low   = stg_data[NUM_STAGES].state[63:0];
   assign rsp_data.bad_mode     = stg_data[NUM_STAGES].bad_mode;

endmodule

/* src/aes_chk.sv */
// Port-level checker for the AES-128 ECB encrypt block, bound to the top level.
`include "aes128_ecb_encrypt_assert.svh"

module aes_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input aes_pkg::aes_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input aes_pkg::aes_rsp_type rsp_data,
   input logic                 psel,
   input logic                 penable,
   input logic                 pwrite,
   input logic [3:0]           paddr,
   input logic [63:0]          pwdata,
   input logic [63:0]          prdata,
   input logic                 pready
);
   import aes_pkg::*;

   // A stalled result keeps its valid and payload.
   `AES_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Error results carry a zero block.
   `AES_ASSERT_IMP(a_bad_zero, clock, reset, rsp_valid && rsp_data.bad_mode, rsp_data.cipher_high == '0 && rsp_data.cipher_low == '0, "error result not zero")

   // Reset empties the pipeline.
   `AES_ASSERT_RAW(a_rst_empty, clock, $past(reset), !rsp_valid, "result valid right after reset")

   // Configuration port never waits.
   `AES_ASSERT_IMP(a_pready, clock, reset, psel, pready, "pready low")

endmodule

bind aes128_ecb_encrypt aes_chk u_aes_chk (.*);

/* bench/aes_cipher_checker.sv */
// Checker for the AES-128 ECB encrypt block: predicts each ciphertext and compares results.
module aes_cipher_checker #(
   parameter logic [3:0] KEY_HIGH_ADDR = 4'd0,
   parameter logic [3:0] KEY_LOW_ADDR  = 4'd8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  aes_pkg::aes_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  aes_pkg::aes_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [3:0]           paddr,
   input  logic [63:0]          pwdata,
   output int                   fail_count,
   output int                   pending,
   output int                   checked
);

   localparam logic [7:0] AES_POLY    = 8'h1b;
   localparam logic [7:0] SBOX_AFFINE = 8'h63;
   localparam int         AES_ROUNDS  = 10;

   // S-box built from the field inverse and the affine map, not from a table
   logic [7:0]           sub_bytes_lut [256];
   logic [63:0]          key_high_copy;
   logic [63:0]          key_low_copy;
   aes_pkg::aes_rsp_type expected_ciphers [$];

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= x;
         x = {x[6:0], 1'b0} ^ (x[7] ? AES_POLY : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
      logic [15:0] w;
      w = {b, b} << n;
      return w[15:8];
   endfunction

   // Byte i of the state sits at bits 127-8i down; columns of four bytes
   function automatic logic [127:0] sub_shift_rows(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (c * 4 + r) -: 8] =
               sub_bytes_lut[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
         end
      end
      return t;
   endfunction

   // Matrix form: rows 2 3 1 1 rotated
   function automatic logic [127:0] col_mix_gf(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
         t[103 - 32 * c -: 8] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
      end
      return t;
   endfunction

   function automatic logic [127:0] predict_block(input logic [127:0] plain,
                                                  input logic [127:0] key);
      logic [31:0]  w [44];
      logic [31:0]  tw;
      logic [7:0]   rc;
      logic [127:0] s;
      for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
      // key expansion; round constant doubles in the field each round
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         tw = w[i - 1];
         if (i % 4 == 0) begin
            tw = {sub_bytes_lut[tw[23:16]] ^ rc, sub_bytes_lut[tw[15:8]],
                  sub_bytes_lut[tw[7:0]], sub_bytes_lut[tw[31:24]]};
            rc = gf_mul(rc, 8'h02);
         end
         w[i] = w[i - 4] ^ tw;
      end
      s = plain ^ {w[0], w[1], w[2], w[3]};
      for (int rnd = 1; rnd <= AES_ROUNDS; rnd++) begin
         s = sub_shift_rows(s);
         if (rnd < AES_ROUNDS) s = col_mix_gf(s);
         s ^= {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]};
      end
      return s;
   endfunction

   function automatic aes_pkg::aes_rsp_type predict_cipher(input aes_pkg::aes_req_type r);
      aes_pkg::aes_rsp_type p;
      logic [127:0]         c;
      if (r.decrypt_request) begin
         // decrypt is unsupported: zero data with the mode flag
         p.cipher_high = '0;
         p.cipher_low  = '0;
         p.bad_mode    = 1'b1;
      end else begin
         c = predict_block({r.block_high, r.block_low},
                           {key_high_copy, key_low_copy});
         p.cipher_high = c[127:64];
         p.cipher_low  = c[63:0];
         p.bad_mode    = 1'b0;
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [127:0] want,
                                  input logic [127:0] got);
      $display("MISMATCH result %0d %s: expected %h got %h", checked, what, want, got);
      fail_count++;
   endtask

   // Build the S-box and check the cipher against a published known answer
   initial begin : build_sbox
      logic [7:0]   inv;
      logic [127:0] c;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         sub_bytes_lut[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                            ^ rotl8(inv, 4) ^ SBOX_AFFINE;
      end
      c = predict_block(128'h00112233445566778899aabbccddeeff,
                        128'h000102030405060708090a0b0c0d0e0f);
      if (c != 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
         report_mismatch("known answer of predictor", 128'h69c4e0d86a7b0430d8cdb78070b4c55a, c);
   end

   // Watch both channels and the register port at every rising edge
   always @(posedge clock) begin : watch
      aes_pkg::aes_rsp_type want;
      if (reset) begin
         key_high_copy = '0;
         key_low_copy  = '0;
      end else begin
         // request transfer: predict with the key in force now
         if (req_valid && req_ready) expected_ciphers.push_back(predict_cipher(req_data));
         // result transfer: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_ciphers.size() == 0) begin
               report_mismatch("with nothing outstanding", '0,
                               {rsp_data.cipher_high, rsp_data.cipher_low});
            end else begin
               want = expected_ciphers.pop_front();
               if (rsp_data.cipher_high !== want.cipher_high)
                  report_mismatch("cipher_high", 128'(want.cipher_high),
                                  128'(rsp_data.cipher_high));
               if (rsp_data.cipher_low !== want.cipher_low)
                  report_mismatch("cipher_low", 128'(want.cipher_low),
                                  128'(rsp_data.cipher_low));
               if (rsp_data.bad_mode !== want.bad_mode)
                  report_mismatch("bad_mode", 128'(want.bad_mode), 128'(rsp_data.bad_mode));
               checked++;
            end
         end
         // register write transfer
         if (psel && penable && pwrite && pready) begin
            if (paddr == KEY_HIGH_ADDR) key_high_copy = pwdata;
            else if (paddr == KEY_LOW_ADDR) key_low_copy = pwdata;
         end
      end
      pending = expected_ciphers.size();
   end

endmodule

/* bench/testbench.sv */
// Top of the AES-128 ECB encrypt bench: clock, reset, stimulus and verdict.
module testbench;

   import aes_pkg::*;

   localparam logic [3:0] KEY_HIGH_ADDR   = 4'd0;
   localparam logic [3:0] KEY_LOW_ADDR    = 4'd8;
   localparam int         IDLE_LIMIT      = 2000;
   localparam int         SETTLE_CYCLES   = 16;
   localparam int         RANDOM_PHASES   = 8;
   localparam int         ITEMS_PER_PHASE = 250;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   aes_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   aes_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   int   fail_count;
   int   pending;
   int   checked;
   int   idle_cycles = 0;
   int   blocks_sent = 0;
   int   decrypts_sent = 0;
   int   key_writes = 0;
   logic no_idle;

   aes128_ecb_encrypt dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   aes_cipher_checker #(
      .KEY_HIGH_ADDR (KEY_HIGH_ADDR),
      .KEY_LOW_ADDR  (KEY_LOW_ADDR)
   ) cipher_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: too many cycles without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side back-pressure
   initial begin : result_stall
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   function automatic aes_req_type make_req(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic dec);
      aes_req_type r;
      r.block_high      = hi;
      r.block_low       = lo;
      r.decrypt_request = dec;
      return r;
   endfunction

   function automatic aes_req_type random_block();
      aes_req_type r;
      int          sel;
      r.block_high      = {$urandom, $urandom};
      r.block_low       = {$urandom, $urandom};
      r.decrypt_request = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 15);
      case (sel)
         0: r.block_high = '0;
         1: r.block_high = '1;
         2: r.block_low  = '0;
         3: r.block_low  = '1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] random_key_half();
      logic [63:0] k;
      int          sel;
      k   = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel == 0) k = '0;
      else if (sel == 1) k = '1;
      return k;
   endfunction

   // One request transfer; valid stays high when the next item follows at once
   task automatic send_block(input aes_req_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      blocks_sent++;
      if (item.decrypt_request) decrypts_sent++;
   endtask

   // Stop sending and wait until every predicted result has arrived
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      key_writes++;
   endtask

   task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
      write_key(KEY_HIGH_ADDR, hi);
      write_key(KEY_LOW_ADDR, lo);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      no_idle   = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Key left at its reset value of zero
      send_block(make_req('0, '0, 1'b0));
      send_block(make_req('1, '1, 1'b0));
      send_block(make_req(64'h8000_0000_0000_0000, '0, 1'b0));
      send_block(make_req('0, 64'h0000_0000_0000_0001, 1'b0));
      send_block(make_req('1, '1, 1'b1));
      send_block(make_req('0, '0, 1'b1));

      // Published AES-128 vectors
      drain();
      set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(make_req(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      send_block(make_req(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1));
      send_block(make_req('0, '1, 1'b0));
      drain();
      set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_block(make_req(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0));
      send_block(make_req('1, '0, 1'b0));

      // Key extremes
      drain();
      set_key('1, '1);
      send_block(make_req('0, '0, 1'b0));
      send_block(make_req('1, '1, 1'b0));
      send_block(make_req(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1));
      drain();
      set_key('0, '1);
      send_block(make_req('0, '0, 1'b0));
      drain();
      set_key('1, '0);
      send_block(make_req('1, '1, 1'b0));

      // Random phases, each under a new key; some registers rewritten alone
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         case (p % 3)
            0: set_key(random_key_half(), random_key_half());
            1: write_key(KEY_LOW_ADDR, random_key_half());
            default: write_key(KEY_HIGH_ADDR, random_key_half());
         endcase
         no_idle = (p % 4 == 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // hold off mid-phase until the pipeline is empty
            if (i == ITEMS_PER_PHASE / 2) drain();
            send_block(random_block());
         end
      end

      drain();
      $display("Covered %0d blocks, %0d of them decrypt requests, across %0d key writes",
               blocks_sent, decrypts_sent, key_writes);
      $display("Compared %0d ciphertext results field by field, %0d mismatches",
               checked, fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
